/* design/hashed_name_seen_set_assert.svh */
// assertion macros shared by the hashed name seen set design
`ifndef HASHED_NAME_SEEN_SET_ASSERT_SVH
`define HASHED_NAME_SEEN_SET_ASSERT_SVH

// same-cycle implication, sampled on clk and ignored while rst_n is low
`define HNSS_ASSERT_IMPLIES(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("hnss assertion failed");

// condition that must never hold out of reset
`define HNSS_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hnss assertion failed");

`endif

/* design/hnss_pkg.sv */
`default_nettype none

package hnss_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRIES_W   = 11;
    localparam int HASH_W      = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [HASH_W-1:0] FNV_PRIME = 64'h00000100000001b3;

    // command handed from the front to the back
    typedef struct packed {
        logic              clear;
        logic [HASH_W-1:0] hash;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // one fnv-1a step; the prime is 2^40 + 0x1b3, so the product is shifts and adds
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

/* design/hnss_fifo.sv */
`default_nettype none

module hnss_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hnss_pkg::cmd_t    push_cmd,
    input  wire logic              pop,
    output hnss_pkg::cmd_t         head_cmd,
    output hnss_pkg::q_status_t    status
);

    hnss_pkg::cmd_t            slot_reg [hnss_pkg::QUEUE_DEPTH];
    logic [hnss_pkg::QPTR_W:0] wr_ptr_reg;
    logic [hnss_pkg::QPTR_W:0] rd_ptr_reg;

    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.full  = (wr_ptr_reg[hnss_pkg::QPTR_W] != rd_ptr_reg[hnss_pkg::QPTR_W]) &&
                          (wr_ptr_reg[hnss_pkg::QPTR_W-1:0] == rd_ptr_reg[hnss_pkg::QPTR_W-1:0]);
    assign head_cmd     = slot_reg[rd_ptr_reg[hnss_pkg::QPTR_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg[hnss_pkg::QPTR_W-1:0]] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/hnss_front.sv */
`default_nettype none

module hnss_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [7:0]        name_byte,
    input  wire logic              last_byte,
    input  wire hnss_pkg::q_status_t q_status,
    output logic                   q_push,
    output hnss_pkg::cmd_t         q_cmd
);

    logic [hnss_pkg::HASH_W-1:0] hash_reg;
    logic [hnss_pkg::HASH_W-1:0] hash_next;
    logic [hnss_pkg::HASH_W-1:0] folded;
    logic                        accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign folded   = hnss_pkg::fnv_fold(hash_reg, name_byte);

    // only clears and finished names go to the back
    assign q_push      = accept && (kind || last_byte);
    assign q_cmd.clear = kind;
    assign q_cmd.hash  = folded;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            if (kind || last_byte)
            begin
                hash_next = hnss_pkg::FNV_BASIS;
            end
            else
            begin
                hash_next = folded;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= hnss_pkg::FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

/* design/hnss_back.sv */
`default_nettype none

module hnss_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire hnss_pkg::cmd_t         head_cmd,
    input  wire hnss_pkg::q_status_t    q_status,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        seen,
    output logic                        inserted,
    output logic                        table_full,
    output logic [hnss_pkg::HASH_W-1:0]    name_hash,
    output logic [hnss_pkg::ENTRIES_W-1:0] entries_used
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

    state_t                         state_reg, state_next;
    logic [hnss_pkg::HASH_W-1:0]    key_reg, key_next;
    logic [hnss_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [hnss_pkg::CNT_W-1:0]     issue_reg, issue_next;
    logic                           pend_reg, pend_next;
    logic                           seen_reg, seen_next;
    logic                           ins_reg, ins_next;
    logic                           full_reg, full_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_seen_reg, out_seen_next;
    logic                           out_ins_reg, out_ins_next;
    logic                           out_full_reg, out_full_next;
    logic [hnss_pkg::HASH_W-1:0]    out_hash_reg, out_hash_next;
    logic [hnss_pkg::ENTRIES_W-1:0] out_used_reg, out_used_next;

    logic [hnss_pkg::HASH_W-1:0]    mem [hnss_pkg::TABLE_DEPTH];
    logic [hnss_pkg::HASH_W-1:0]    rd_data_reg;
    logic                           wr_en;
    logic                           hit;
    logic                           exhausted;
    logic                           at_cap;

    assign hit       = pend_reg && (rd_data_reg == key_reg);
    assign exhausted = (issue_reg == count_reg);
    assign at_cap    = (count_reg == hnss_pkg::CNT_W'(hnss_pkg::TABLE_DEPTH));
    assign q_pop     = (state_reg == ST_IDLE) && !q_status.empty;
    assign wr_en     = (state_reg == ST_SCAN) && !hit && !pend_reg && exhausted && !at_cap;

    assign out_valid    = out_valid_reg;
    assign seen         = out_seen_reg;
    assign inserted     = out_ins_reg;
    assign table_full   = out_full_reg;
    assign name_hash    = out_hash_reg;
    assign entries_used = out_used_reg;

    // one read per cycle, data lands in the next cycle through rd_data_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[hnss_pkg::IDX_W-1:0]] <= key_reg;
        end
        rd_data_reg <= mem[issue_reg[hnss_pkg::IDX_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        seen_next      = seen_reg;
        ins_next       = ins_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_seen_next  = out_seen_reg;
        out_ins_next   = out_ins_reg;
        out_full_next  = out_full_reg;
        out_hash_next  = out_hash_reg;
        out_used_next  = out_used_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (head_cmd.clear)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        key_next   = head_cmd.hash;
                        issue_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!exhausted)
                begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                if (hit)
                begin
                    seen_next  = 1'b1;
                    ins_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else if (!pend_reg && exhausted)
                begin
                    seen_next  = 1'b0;
                    ins_next   = !at_cap;
                    full_next  = at_cap;
                    if (!at_cap)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_seen_next  = seen_reg;
                    out_ins_next   = ins_reg;
                    out_full_next  = full_reg;
                    out_hash_next  = key_reg;
                    out_used_next  = hnss_pkg::ENTRIES_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_reg       <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_seen_reg  <= 1'b0;
            out_ins_reg   <= 1'b0;
            out_full_reg  <= 1'b0;
            out_hash_reg  <= '0;
            out_used_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            seen_reg      <= seen_next;
            ins_reg       <= ins_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            out_seen_reg  <= out_seen_next;
            out_ins_reg   <= out_ins_next;
            out_full_reg  <= out_full_next;
            out_hash_reg  <= out_hash_next;
            out_used_reg  <= out_used_next;
        end
    end

endmodule

`default_nettype wire

/* design/hashed_name_seen_set.sv */
// name bytes: one word per cycle while in_ready is high; a byte that is not last gives no result
// last byte: the result follows a back end search over the N stored hashes, the
//   back end reading the hash table one entry per cycle through its single read port
// a clear word zeroes the count in the back end and gives no result; the front keeps taking words while the
//   two-entry queue has room, so bytes stream at one per cycle while the queue is not full
// reset: asynchronous, active low; hash back to the offset basis, count to zero, queue
//   and output emptied; the table ram is not swept, entries above the count are never compared
`default_nettype none
`include "hashed_name_seen_set_assert.svh"

module hashed_name_seen_set (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input words
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      kind,
    input  wire logic [7:0]                name_byte,
    input  wire logic                      last_byte,
    // result words
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           seen,
    output logic                           inserted,
    output logic                           table_full,
    output logic [hnss_pkg::HASH_W-1:0]    name_hash,
    output logic [hnss_pkg::ENTRIES_W-1:0] entries_used
);

    // front to queue
    logic                q_push;
    hnss_pkg::cmd_t      q_cmd;
    // queue to back
    logic                q_pop;
    hnss_pkg::cmd_t      head_cmd;
    hnss_pkg::q_status_t q_status;

    // front: folds each byte into the running fnv-1a hash, hands finished
    // names and clear words to the queue
    hnss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .name_byte (name_byte),
        .last_byte (last_byte),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // short queue so the front keeps hashing while the back searches
    hnss_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // back: linear search of the stored hashes, append or full flag,
    // result held in an output register
    hnss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .q_status     (q_status),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seen         (seen),
        .inserted     (inserted),
        .table_full   (table_full),
        .name_hash    (name_hash),
        .entries_used (entries_used)
    );

    // exactly one outcome per result word
    `HNSS_ASSERT_IMPLIES(a_one_outcome, out_valid, $onehot({seen, inserted, table_full}))
    // a dropped hash only when the table holds its full depth
    `HNSS_ASSERT_IMPLIES(a_full_count, out_valid && table_full, entries_used == hnss_pkg::ENTRIES_W'(hnss_pkg::TABLE_DEPTH))
    // the front never writes into a full queue
    `HNSS_ASSERT_NEVER(a_no_overflow, q_push && q_status.full)
    // the back never pops an empty queue
    `HNSS_ASSERT_NEVER(a_no_underflow, q_pop && q_status.empty)

endmodule

`default_nettype wire
